@@ hw/rtl/fuel_gauge_sample_conditioner_unit_macros.svh @@
// ----------------------------------------------------------------------------
// fuel gauge sample conditioner assertion macros
// concurrent check helpers clocked on aclk, disabled while aresetn is low
// ----------------------------------------------------------------------------
`ifndef FUEL_GAUGE_SAMPLE_CONDITIONER_UNIT_MACROS_SVH
`define FUEL_GAUGE_SAMPLE_CONDITIONER_UNIT_MACROS_SVH

// same-cycle implication
`define FGSC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error("fgsc check failed");

// next-cycle implication
`define FGSC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error("fgsc check failed");

`endif

@@ hw/rtl/fgsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fgsc_pkg
// shared widths, register map, codes and types of the sample conditioner
// ----------------------------------------------------------------------------
package fgsc_pkg;

    localparam int WINDOW_DEPTH = 10;

    localparam int CELL_W   = 23;
    localparam int RAW_W    = 15;
    localparam int PCT_W    = 7;
    localparam int MARGIN_W = 11;
    localparam int WORD_W   = 16;

    localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int POS_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int TOTAL_W = CELL_W + $clog2(WINDOW_DEPTH);
    localparam int NUM_W   = RAW_W + PCT_W;

    localparam int DIVIDEND_W = (TOTAL_W > NUM_W) ? TOTAL_W : NUM_W;
    localparam int DIVISOR_W  = (RAW_W > FILL_W) ? RAW_W : FILL_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

    localparam int CELL_LSB_UV = 1250;
    localparam int PERCENT     = 100;
    // 1953125 / 10000000 = 25 / 128
    localparam int HV_NUM      = 25;
    localparam int HV_SHIFT    = 7;
    localparam int HV_PROD_W   = WORD_W + 5;

    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 5;
    localparam int REG_IDX_W = ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_HIGH_VOLTAGE_SCALE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_EMPTY_LEVEL        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_FULL_DEFAULT       = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_FIXED_FULL_MODE    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_FULL_LOW_LIMIT     = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FULL_HIGH_LIMIT    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_FULL_MARGIN        = 3'd6;

    localparam logic [RAW_W-1:0]    EMPTY_LEVEL_RST     = 15'd110;
    localparam logic [RAW_W-1:0]    FULL_DEFAULT_RST    = 15'd10000;
    localparam logic [RAW_W-1:0]    FULL_LOW_LIMIT_RST  = 15'd9300;
    localparam logic [RAW_W-1:0]    FULL_HIGH_LIMIT_RST = 15'd10100;
    localparam logic [MARGIN_W-1:0] FULL_MARGIN_RST     = 11'd50;

    localparam logic OP_SAMPLE       = 1'b0;
    localparam logic OP_CHARGER_FULL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CELL,
        ST_TOTAL,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_PCT_START,
        ST_PCT_WAIT,
        ST_LEARN,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctrl_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

@@ hw/rtl/fgsc_divider.sv @@
// ----------------------------------------------------------------------------
// fgsc_divider
// restoring bit-serial unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module fgsc_divider (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  fgsc_pkg::div_ctrl_t               ctrl,
    input  logic [fgsc_pkg::DIVIDEND_W-1:0]   dividend,
    input  logic [fgsc_pkg::DIVISOR_W-1:0]    divisor,
    output fgsc_pkg::div_stat_t               stat,
    output logic [fgsc_pkg::DIVIDEND_W-1:0]   quotient
);
    import fgsc_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  div_reg;

    logic [DIVISOR_W:0]    trial;
    logic                  take;
    logic [DIVISOR_W:0]    diff;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign take  = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctrl.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            div_reg <= divisor;
        end else if (busy_reg) begin
            rem_reg <= take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], take};
        end
    end

    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

@@ hw/rtl/fuel_gauge_sample_conditioner_unit.sv @@
// ----------------------------------------------------------------------------
// fuel_gauge_sample_conditioner_unit
// cell voltage moving average and rescaled state of charge for a fuel gauge
// ----------------------------------------------------------------------------
// A sample transaction (opcode 0) converts the voltage word to microvolts,
// pushes it into a ring of WINDOW_DEPTH entries and reports the floored
// average of the filled entries, together with the raw charge in hundredths
// of a percent and the charge rescaled between the empty and full levels in
// whole percent. A charger-full transaction (opcode 1) re-learns the full
// level from the last raw charge and repeats the last sample's results.
// One transaction is in work at a time and s_ready is low meanwhile. In a
// sample the bit-serial divider runs first for the average and then for
// the percentage; when the full level is not above empty or the charge is
// at or below empty the second run is skipped. The result sits in an output
// register, so the next transaction is accepted while it waits for m_ready.
// Configuration registers are 32-bit words at byte address 4*index.
// ----------------------------------------------------------------------------
module fuel_gauge_sample_conditioner_unit (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_opcode,
    input  logic [fgsc_pkg::WORD_W-1:0]   s_voltage_word,
    input  logic [fgsc_pkg::WORD_W-1:0]   s_charge_word,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [fgsc_pkg::CELL_W-1:0]   m_cell_microvolts,
    output logic [fgsc_pkg::CELL_W-1:0]   m_average_microvolts,
    output logic [fgsc_pkg::RAW_W-1:0]    m_raw_charge,
    output logic [fgsc_pkg::PCT_W-1:0]    m_charge_percent,
    output logic [fgsc_pkg::RAW_W-1:0]    m_learned_full,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fgsc_pkg::ADDR_W-1:0]   paddr,
    input  logic [fgsc_pkg::DATA_W-1:0]   pwdata,
    output logic [fgsc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import fgsc_pkg::*;

    // configuration
    logic                high_voltage_scale_reg;
    logic [RAW_W-1:0]    empty_level_reg;
    logic [RAW_W-1:0]    full_default_reg;
    logic                fixed_full_mode_reg;
    logic [RAW_W-1:0]    full_low_limit_reg;
    logic [RAW_W-1:0]    full_high_limit_reg;
    logic [MARGIN_W-1:0] full_margin_reg;

    logic                 cfg_write;
    logic [REG_IDX_W-1:0] cfg_idx;

    // sequencer and datapath
    state_t              state_reg, state_next;
    logic [WORD_W-1:0]   vword_reg;
    logic [WORD_W-1:0]   cword_reg;

    logic [FILL_W-1:0]   fill_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic                evict_reg;
    logic [CELL_W-1:0]   old_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [TOTAL_W-1:0]  total_next;

    logic [CELL_W-1:0]   cell_reg;
    logic [CELL_W-1:0]   avg_reg;
    logic [RAW_W-1:0]    raw_reg;
    logic [PCT_W-1:0]    pct_reg;
    logic [RAW_W-1:0]    full_level_reg;

    logic [NUM_W-1:0]    num_reg;
    logic [RAW_W-1:0]    den_reg;
    logic                special_reg;
    logic [PCT_W-1:0]    special_pct_reg;

    logic [CELL_W-1:0]   window_mem [WINDOW_DEPTH];

    logic [CELL_W-1:0]   cell_calc;
    logic [RAW_W-1:0]    raw_calc;
    logic [RAW_W-1:0]    full_sel;
    logic [RAW_W-1:0]    learned_calc;
    logic [PCT_W-1:0]    pct_calc;

    div_ctrl_t             div_ctrl;
    div_stat_t             div_stat;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [DIVIDEND_W-1:0] div_quotient;

    logic                out_load;
    logic                m_valid_reg, m_valid_next;
    logic [CELL_W-1:0]   m_cell_reg;
    logic [CELL_W-1:0]   m_avg_reg;
    logic [RAW_W-1:0]    m_raw_reg;
    logic [PCT_W-1:0]    m_pct_reg;
    logic [RAW_W-1:0]    m_full_reg;

    function automatic logic [RAW_W-1:0] charge_from_word(
        input logic              hv,
        input logic [WORD_W-1:0] word
    );
        logic [RAW_W-1:0]     msb_part;
        logic [RAW_W-1:0]     lsb_prod;
        logic [HV_PROD_W-1:0] hv_prod;
        msb_part = RAW_W'(word[15:8]) * RAW_W'(PERCENT);
        lsb_prod = RAW_W'(word[7:0]) * RAW_W'(PERCENT);
        hv_prod  = HV_PROD_W'(word) * HV_PROD_W'(HV_NUM);
        if (hv) begin
            charge_from_word = RAW_W'(hv_prod >> HV_SHIFT);
        end else begin
            charge_from_word = msb_part + (lsb_prod >> 8);
        end
    endfunction

    function automatic logic [RAW_W-1:0] learn_level(
        input logic [RAW_W-1:0]    raw,
        input logic [RAW_W-1:0]    low,
        input logic [RAW_W-1:0]    high,
        input logic [MARGIN_W-1:0] margin
    );
        logic [RAW_W:0] low_plus;
        low_plus = {1'b0, low} + (RAW_W + 1)'(margin);
        if (raw < low) begin
            learn_level = low;
        end else if (raw > high) begin
            learn_level = (high > RAW_W'(margin)) ? high - RAW_W'(margin) : '0;
        end else if ({1'b0, raw} > low_plus) begin
            learn_level = raw - RAW_W'(margin);
        end else begin
            learn_level = low;
        end
    endfunction

    // configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_voltage_scale_reg <= 1'b0;
            empty_level_reg        <= EMPTY_LEVEL_RST;
            full_default_reg       <= FULL_DEFAULT_RST;
            fixed_full_mode_reg    <= 1'b0;
            full_low_limit_reg     <= FULL_LOW_LIMIT_RST;
            full_high_limit_reg    <= FULL_HIGH_LIMIT_RST;
            full_margin_reg        <= FULL_MARGIN_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_HIGH_VOLTAGE_SCALE: high_voltage_scale_reg <= pwdata[0];
                REG_EMPTY_LEVEL:        empty_level_reg        <= pwdata[RAW_W-1:0];
                REG_FULL_DEFAULT:       full_default_reg       <= pwdata[RAW_W-1:0];
                REG_FIXED_FULL_MODE:    fixed_full_mode_reg    <= pwdata[0];
                REG_FULL_LOW_LIMIT:     full_low_limit_reg     <= pwdata[RAW_W-1:0];
                REG_FULL_HIGH_LIMIT:    full_high_limit_reg    <= pwdata[RAW_W-1:0];
                REG_FULL_MARGIN:        full_margin_reg        <= pwdata[MARGIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HIGH_VOLTAGE_SCALE: prdata = DATA_W'(high_voltage_scale_reg);
            REG_EMPTY_LEVEL:        prdata = DATA_W'(empty_level_reg);
            REG_FULL_DEFAULT:       prdata = DATA_W'(full_default_reg);
            REG_FIXED_FULL_MODE:    prdata = DATA_W'(fixed_full_mode_reg);
            REG_FULL_LOW_LIMIT:     prdata = DATA_W'(full_low_limit_reg);
            REG_FULL_HIGH_LIMIT:    prdata = DATA_W'(full_high_limit_reg);
            REG_FULL_MARGIN:        prdata = DATA_W'(full_margin_reg);
            default:                prdata = '0;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_opcode == OP_SAMPLE) ? ST_CELL : ST_LEARN;
                end
            end
            ST_CELL:      state_next = ST_TOTAL;
            ST_TOTAL:     state_next = ST_AVG_START;
            ST_AVG_START: state_next = ST_AVG_WAIT;
            ST_AVG_WAIT: begin
                if (div_stat.done) begin
                    state_next = special_reg ? ST_OUT : ST_PCT_START;
                end
            end
            ST_PCT_START: state_next = ST_PCT_WAIT;
            ST_PCT_WAIT: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_LEARN:     state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        s_ready        = 1'b0;
        div_ctrl.start = 1'b0;
        out_load       = 1'b0;
        div_dividend   = DIVIDEND_W'(num_reg);
        div_divisor    = DIVISOR_W'(den_reg);
        case (state_reg)
            ST_IDLE:      s_ready = 1'b1;
            ST_AVG_START: begin
                div_ctrl.start = 1'b1;
                div_dividend   = DIVIDEND_W'(total_reg);
                div_divisor    = DIVISOR_W'(fill_reg);
            end
            ST_PCT_START: div_ctrl.start = 1'b1;
            ST_OUT:       out_load = !m_valid_reg || m_ready;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    assign cell_calc = CELL_W'(vword_reg[15:4]) * CELL_W'(CELL_LSB_UV);
    assign raw_calc  = charge_from_word(high_voltage_scale_reg, cword_reg);
    assign full_sel  = fixed_full_mode_reg ? full_default_reg : full_level_reg;
    assign learned_calc = learn_level(raw_reg, full_low_limit_reg,
                                      full_high_limit_reg, full_margin_reg);
    assign pct_calc  = (div_quotient > DIVIDEND_W'(PERCENT)) ? PCT_W'(PERCENT)
                                                             : div_quotient[PCT_W-1:0];

    always_comb begin
        if (fill_reg < FILL_W'(WINDOW_DEPTH)) begin
            pos_next = fill_reg[POS_W-1:0];
        end else if (pos_reg == POS_W'(WINDOW_DEPTH - 1)) begin
            pos_next = '0;
        end else begin
            pos_next = pos_reg + 1'b1;
        end
    end

    assign total_next = total_reg - (evict_reg ? TOTAL_W'(old_reg) : '0)
                      + TOTAL_W'(cell_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg       <= '0;
            pos_reg        <= '0;
            total_reg      <= '0;
            cell_reg       <= '0;
            avg_reg        <= '0;
            raw_reg        <= '0;
            pct_reg        <= '0;
            full_level_reg <= FULL_DEFAULT_RST;
        end else begin
            case (state_reg)
                ST_CELL: begin
                    pos_reg  <= pos_next;
                    cell_reg <= cell_calc;
                    raw_reg  <= raw_calc;
                    if (fill_reg < FILL_W'(WINDOW_DEPTH)) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                end
                ST_TOTAL:     total_reg <= total_next;
                ST_AVG_WAIT: begin
                    if (div_stat.done) begin
                        avg_reg <= div_quotient[CELL_W-1:0];
                        if (special_reg) begin
                            pct_reg <= special_pct_reg;
                        end
                    end
                end
                ST_PCT_WAIT: begin
                    if (div_stat.done) begin
                        pct_reg <= pct_calc;
                    end
                end
                ST_LEARN:     full_level_reg <= learned_calc;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_valid) begin
            vword_reg  <= s_voltage_word;
            cword_reg  <= s_charge_word;
        end
        if (state_reg == ST_CELL) begin
            evict_reg <= (fill_reg == FILL_W'(WINDOW_DEPTH));
        end
        if (state_reg == ST_TOTAL) begin
            num_reg <= NUM_W'(raw_reg - empty_level_reg) * NUM_W'(PERCENT);
            den_reg <= full_sel - empty_level_reg;
            if (full_sel <= empty_level_reg) begin
                special_reg     <= 1'b1;
                special_pct_reg <= PCT_W'(PERCENT);
            end else if (raw_reg <= empty_level_reg) begin
                special_reg     <= 1'b1;
                special_pct_reg <= '0;
            end else begin
                special_reg     <= 1'b0;
                special_pct_reg <= '0;
            end
        end
    end

    // voltage ring
    always_ff @(posedge aclk) begin
        if (state_reg == ST_CELL) begin
            old_reg <= window_mem[pos_next];
        end
        if (state_reg == ST_TOTAL) begin
            window_mem[pos_reg] <= cell_reg;
        end
    end

    fgsc_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // result register
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_cell_reg <= cell_reg;
            m_avg_reg  <= avg_reg;
            m_raw_reg  <= raw_reg;
            m_pct_reg  <= pct_reg;
            m_full_reg <= full_level_reg;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_cell_microvolts    = m_cell_reg;
    assign m_average_microvolts = m_avg_reg;
    assign m_raw_charge         = m_raw_reg;
    assign m_charge_percent     = m_pct_reg;
    assign m_learned_full       = m_full_reg;

endmodule

@@ hw/rtl/fgsc_checker.sv @@
// ----------------------------------------------------------------------------
// fgsc_checker
// port-level checks of the sample conditioner, bound to the top level
// ----------------------------------------------------------------------------
`include "fuel_gauge_sample_conditioner_unit_macros.svh"

module fgsc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [fgsc_pkg::CELL_W-1:0]   m_cell_microvolts,
    input logic [fgsc_pkg::CELL_W-1:0]   m_average_microvolts,
    input logic [fgsc_pkg::PCT_W-1:0]    m_charge_percent
);
    import fgsc_pkg::*;

    // stalled result stays offered
    `FGSC_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid)

    // one transaction in work at a time
    `FGSC_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)

    `FGSC_ASSERT_SAME(a_percent_clamped, m_valid, m_charge_percent <= PCT_W'(PERCENT))

    `FGSC_ASSERT_SAME(a_voltage_range, m_valid,
        (m_cell_microvolts <= 23'd5118750) && (m_average_microvolts <= 23'd5118750))

endmodule

bind fuel_gauge_sample_conditioner_unit fgsc_checker u_fgsc_checker (.*);

@@ dv/fuel_gauge_sample_conditioner_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuel_gauge_sample_conditioner_unit_test
// self-checking bench for the cell voltage averager and charge rescaler
// ----------------------------------------------------------------------------
// A short table of hand-picked transactions runs at reset settings. Random
// transactions follow under several register settings, the extremes among
// them. Every accepted transaction goes through a local model of the voltage
// window, the charge scaling and the full-level learning. Each result is
// compared field by field with the oldest prediction. Register writes are
// read back. Both handshakes stall at random, and one phase runs without gaps.
// ----------------------------------------------------------------------------
module fuel_gauge_sample_conditioner_unit_test;

    import fgsc_pkg::*;

    localparam int STALL_LIMIT   = 5000;
    localparam int PHASES        = 8;
    localparam int ITEMS_A_PHASE = 66;
    localparam int MAX_RAW       = 25599;

    typedef struct packed {
        logic [CELL_W-1:0] cell_uv;
        logic [CELL_W-1:0] avg_uv;
        logic [RAW_W-1:0]  raw;
        logic [PCT_W-1:0]  pct;
        logic [RAW_W-1:0]  full_lvl;
    } reading_t;

    typedef struct packed {
        logic              op;
        logic [WORD_W-1:0] vword;
        logic [WORD_W-1:0] cword;
        logic              typed;
        reading_t          want;
    } stim_row_t;

    typedef struct packed {
        logic                hv;
        logic [RAW_W-1:0]    empty;
        logic [RAW_W-1:0]    fdef;
        logic                fixed_mode;
        logic [RAW_W-1:0]    low;
        logic [RAW_W-1:0]    high;
        logic [MARGIN_W-1:0] margin;
    } cfg_set_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic                s_opcode;
    logic [WORD_W-1:0]   s_voltage_word;
    logic [WORD_W-1:0]   s_charge_word;
    logic                m_valid;
    logic                m_ready;
    logic [CELL_W-1:0]   m_cell_microvolts;
    logic [CELL_W-1:0]   m_average_microvolts;
    logic [RAW_W-1:0]    m_raw_charge;
    logic [PCT_W-1:0]    m_charge_percent;
    logic [RAW_W-1:0]    m_learned_full;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [DATA_W-1:0]   pwdata;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    fuel_gauge_sample_conditioner_unit dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_opcode             (s_opcode),
        .s_voltage_word       (s_voltage_word),
        .s_charge_word        (s_charge_word),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_cell_microvolts    (m_cell_microvolts),
        .m_average_microvolts (m_average_microvolts),
        .m_raw_charge         (m_raw_charge),
        .m_charge_percent     (m_charge_percent),
        .m_learned_full       (m_learned_full),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // register copies
    int unsigned cfg_hv         = 0;
    int unsigned cfg_empty      = EMPTY_LEVEL_RST;
    int unsigned cfg_full_def   = FULL_DEFAULT_RST;
    int unsigned cfg_fixed_full = 0;
    int unsigned cfg_low        = FULL_LOW_LIMIT_RST;
    int unsigned cfg_high       = FULL_HIGH_LIMIT_RST;
    int unsigned cfg_margin     = FULL_MARGIN_RST;

    // gauge state
    int unsigned     win_uv [WINDOW_DEPTH];
    int unsigned     win_fill      = 0;
    int unsigned     win_pos       = 0;
    longint unsigned win_sum       = 0;
    int unsigned     last_cell     = 0;
    int unsigned     last_avg      = 0;
    int unsigned     last_raw      = 0;
    int unsigned     last_pct      = 0;
    int unsigned     learned_level = FULL_DEFAULT_RST;

    reading_t expected_readings [$];
    reading_t oldest;

    int  failures      = 0;
    int  idle_cycles   = 0;
    int  sample_count  = 0;
    int  charger_count = 0;
    int  results_seen  = 0;
    int  pct_full_seen = 0;
    int  pct_zero_seen = 0;
    int  drain_count   = 0;
    bit  no_gaps       = 1'b0;

    stim_row_t directed_rows [21] = '{
        '{OP_CHARGER_FULL, 16'h0000, 16'h0000, 1'b1,
          '{23'd0, 23'd0, 15'd0, 7'd0, 15'd9300}},
        '{OP_SAMPLE, 16'hFFFF, 16'hFFFF, 1'b1,
          '{23'd5118750, 23'd5118750, 15'd25599, 7'd100, 15'd9300}},
        '{OP_SAMPLE, 16'h000F, 16'h0000, 1'b1,
          '{23'd0, 23'd2559375, 15'd0, 7'd0, 15'd9300}},
        '{OP_CHARGER_FULL, 16'h0000, 16'h0000, 1'b1,
          '{23'd0, 23'd2559375, 15'd0, 7'd0, 15'd9300}},
        '{OP_SAMPLE,       16'hAAAA, 16'h011A, 1'b0, '0},
        '{OP_SAMPLE,       16'h5555, 16'h011B, 1'b0, '0},
        '{OP_SAMPLE,       16'h1230, 16'h6600, 1'b0, '0},
        '{OP_CHARGER_FULL, 16'h0000, 16'h0000, 1'b0, '0},
        '{OP_SAMPLE,       16'h8000, 16'h6000, 1'b0, '0},
        '{OP_CHARGER_FULL, 16'hFFFF, 16'hFFFF, 1'b0, '0},
        '{OP_SAMPLE,       16'h0010, 16'h5D28, 1'b0, '0},
        '{OP_CHARGER_FULL, 16'h0000, 16'h0000, 1'b0, '0},
        '{OP_SAMPLE,       16'hFFF0, 16'h6500, 1'b0, '0},
        '{OP_CHARGER_FULL, 16'h0000, 16'h0000, 1'b0, '0},
        '{OP_SAMPLE,       16'h7FFF, 16'h3280, 1'b0, '0},
        '{OP_SAMPLE,       16'hFFFF, 16'h00FF, 1'b0, '0},
        '{OP_SAMPLE,       16'h0000, 16'h0100, 1'b0, '0},
        '{OP_CHARGER_FULL, 16'h0000, 16'h0000, 1'b0, '0},
        '{OP_SAMPLE,       16'h4000, 16'h1234, 1'b0, '0},
        '{OP_SAMPLE,       16'hC000, 16'hFEDC, 1'b0, '0},
        '{OP_CHARGER_FULL, 16'h0000, 16'h0000, 1'b0, '0}
    };

    cfg_set_t fixed_sets [5] = '{
        '{1'b1, 15'd110,   15'd10000, 1'b0, 15'd9300,  15'd10100, 11'd50},
        '{1'b0, 15'd25599, 15'd25599, 1'b1, 15'd25599, 15'd25599, 11'd2000},
        '{1'b1, 15'd0,     15'd1,     1'b1, 15'd0,     15'd0,     11'd0},
        '{1'b0, 15'd0,     15'd25599, 1'b0, 15'd0,     15'd25599, 11'd2000},
        '{1'b0, 15'd0,     15'd20000, 1'b0, 15'd0,     15'd500,   11'd2000}
    };

    function automatic int unsigned charge_hundredths(logic [WORD_W-1:0] word);
        longint unsigned prod;
        if (cfg_hv != 0) begin
            prod = longint'(word) * 64'd1953125;
            return int'((prod / 64'd10000000) & 64'hFFFF) & 32'h7FFF;
        end
        return (int'(word[15:8]) * 100 + (int'(word[7:0]) * 100) / 256) & 32'h7FFF;
    endfunction

    function automatic int unsigned percent_of(int unsigned raw);
        int unsigned     lvl;
        longint unsigned scaled;
        lvl = (cfg_fixed_full != 0) ? cfg_full_def : learned_level;
        if (lvl <= cfg_empty) return 100;
        if (raw <= cfg_empty) return 0;
        scaled = (longint'(raw - cfg_empty) * 10000) / longint'(lvl - cfg_empty);
        scaled = scaled / 100;
        return (scaled > 100) ? 100 : int'(scaled);
    endfunction

    function automatic reading_t gauge_step(logic op, logic [WORD_W-1:0] v,
                                            logic [WORD_W-1:0] c);
        reading_t r;
        if (op == OP_SAMPLE) begin
            last_cell = int'(v >> 4) * CELL_LSB_UV;
            if (win_fill < WINDOW_DEPTH) begin
                win_pos = win_fill;
                win_fill++;
            end else begin
                win_pos = (win_pos + 1) % WINDOW_DEPTH;
                win_sum -= win_uv[win_pos];
            end
            win_uv[win_pos] = last_cell;
            win_sum += last_cell;
            last_avg = int'(win_sum / win_fill);
            last_raw = charge_hundredths(c);
            last_pct = percent_of(last_raw);
        end else begin
            if (last_raw < cfg_low)
                learned_level = cfg_low;
            else if (last_raw > cfg_high)
                learned_level = (cfg_high > cfg_margin) ? cfg_high - cfg_margin : 0;
            else if (last_raw > cfg_low + cfg_margin)
                learned_level = last_raw - cfg_margin;
            else
                learned_level = cfg_low;
            learned_level &= 32'h7FFF;
        end
        r.cell_uv  = last_cell[CELL_W-1:0];
        r.avg_uv   = last_avg[CELL_W-1:0];
        r.raw      = last_raw[RAW_W-1:0];
        r.pct      = last_pct[PCT_W-1:0];
        r.full_lvl = learned_level[RAW_W-1:0];
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            failures++;
            if (failures <= 10)
                $display("[%0t] %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // charge word that lands near a level of interest in the current scaling
    function automatic logic [WORD_W-1:0] pick_charge_word();
        int target;
        int word;
        case ($urandom_range(0, 6))
            0, 1: return WORD_W'($urandom);
            2: target = cfg_empty;
            3: target = cfg_low;
            4: target = cfg_low + cfg_margin;
            5: target = cfg_high;
            default: target = (cfg_fixed_full != 0) ? cfg_full_def : learned_level;
        endcase
        target = target + $urandom_range(0, 8) - 4;
        if (target < 0) target = 0;
        if (target > MAX_RAW) target = MAX_RAW;
        if (cfg_hv != 0)
            word = target * 128 / 25 + $urandom_range(0, 5);
        else
            word = (target / 100) * 256 + ((target % 100) * 256 + 99) / 100;
        if (word > 65535) word = 65535;
        return WORD_W'(word);
    endfunction

    task automatic apb_transfer(bit is_write, logic [REG_IDX_W-1:0] idx,
                                logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
    endtask

    task automatic write_register(logic [REG_IDX_W-1:0] idx, int unsigned value);
        logic [DATA_W-1:0] rd;
        apb_transfer(1'b1, idx, value, rd);
        apb_transfer(1'b0, idx, '0, rd);
        check_field("register readback", value, rd);
        case (idx)
            REG_HIGH_VOLTAGE_SCALE: cfg_hv         = value;
            REG_EMPTY_LEVEL:        cfg_empty      = value;
            REG_FULL_DEFAULT:       cfg_full_def   = value;
            REG_FIXED_FULL_MODE:    cfg_fixed_full = value;
            REG_FULL_LOW_LIMIT:     cfg_low        = value;
            REG_FULL_HIGH_LIMIT:    cfg_high       = value;
            REG_FULL_MARGIN:        cfg_margin     = value;
            default: ;
        endcase
    endtask

    task automatic apply_config(cfg_set_t cs);
        write_register(REG_HIGH_VOLTAGE_SCALE, cs.hv);
        write_register(REG_EMPTY_LEVEL, cs.empty);
        write_register(REG_FULL_DEFAULT, cs.fdef);
        write_register(REG_FIXED_FULL_MODE, cs.fixed_mode);
        write_register(REG_FULL_LOW_LIMIT, cs.low);
        write_register(REG_FULL_HIGH_LIMIT, cs.high);
        write_register(REG_FULL_MARGIN, cs.margin);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_item(logic op, logic [WORD_W-1:0] v, logic [WORD_W-1:0] c,
                             logic typed, reading_t want);
        reading_t r;
        s_valid        <= 1'b1;
        s_opcode       <= op;
        s_voltage_word <= v;
        s_charge_word  <= c;
        do @(posedge aclk); while (!s_ready);
        r = gauge_step(op, v, c);
        expected_readings.push_back(typed ? want : r);
        if (op == OP_SAMPLE) sample_count++;
        else charger_count++;
    endtask

    task automatic maybe_pause();
        if (!no_gaps && $urandom_range(0, 99) < 20) begin
            s_valid <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 80)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (expected_readings.size() != 0);
    endtask

    always @(posedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(0, 99) >= 20);
    end

    // result checking
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_readings.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("[%0t] result with no pending transaction", $time);
            end else begin
                oldest = expected_readings.pop_front();
                check_field("cell_microvolts", oldest.cell_uv, m_cell_microvolts);
                check_field("average_microvolts", oldest.avg_uv, m_average_microvolts);
                check_field("raw_charge", oldest.raw, m_raw_charge);
                check_field("charge_percent", oldest.pct, m_charge_percent);
                check_field("learned_full", oldest.full_lvl, m_learned_full);
                results_seen++;
                if (oldest.pct == 7'd100) pct_full_seen++;
                if (oldest.pct == 7'd0) pct_zero_seen++;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("** fuel_gauge_sample_conditioner_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        cfg_set_t cs;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_opcode       <= OP_SAMPLE;
        s_voltage_word <= '0;
        s_charge_word  <= '0;
        m_ready        <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].op, directed_rows[i].vword, directed_rows[i].cword,
                      directed_rows[i].typed, directed_rows[i].want);
            maybe_pause();
        end
        s_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            repeat (4) @(posedge aclk);
            if (ph < 5) begin
                cs = fixed_sets[ph];
            end else if (ph == PHASES - 1) begin
                cs.hv         = $urandom_range(0, 1);
                cs.empty      = $urandom_range(0, MAX_RAW);
                cs.fdef       = $urandom_range(1, MAX_RAW);
                cs.fixed_mode = $urandom_range(0, 1);
                cs.low        = $urandom_range(0, MAX_RAW);
                cs.high       = $urandom_range(0, MAX_RAW);
                cs.margin     = $urandom_range(0, 2000);
            end else begin
                cs.hv         = $urandom_range(0, 1);
                cs.empty      = $urandom_range(0, 2500);
                cs.fdef       = $urandom_range(1, MAX_RAW);
                cs.fixed_mode = $urandom_range(0, 1);
                cs.low        = $urandom_range(5000, 15000);
                cs.high       = cs.low + $urandom_range(0, 6000);
                cs.margin     = $urandom_range(0, 2000);
            end
            apply_config(cs);
            no_gaps = (ph == 3);
            for (int i = 0; i < ITEMS_A_PHASE; i++) begin
                send_item(($urandom_range(0, 99) < 20) ? OP_CHARGER_FULL : OP_SAMPLE,
                          WORD_W'($urandom), pick_charge_word(), 1'b0, '0);
                if ($urandom_range(0, 39) == 0) begin
                    s_valid <= 1'b0;
                    wait_drained();
                    drain_count++;
                end else begin
                    maybe_pause();
                end
            end
            s_valid <= 1'b0;
        end
        no_gaps = 1'b0;

        wait_drained();
        repeat (70) @(posedge aclk);
        $display("covered %0d samples and %0d charger-full events under %0d register settings",
                 sample_count, charger_count, PHASES + 1);
        $display("%0d results checked (%0d at 100%%, %0d at 0%%), %0d full drains mid-stream",
                 results_seen, pct_full_seen, pct_zero_seen, drain_count);
        if (failures == 0 && expected_readings.size() == 0) begin
            $display("** fuel_gauge_sample_conditioner_unit: PASSED **");
        end else begin
            $display("%0d failures, %0d results outstanding", failures,
                     expected_readings.size());
            $display("** fuel_gauge_sample_conditioner_unit: FAILED **");
        end
        $finish;
    end

endmodule
